// ===== hw/rtl/cache_set_lru_replacement_top_assert.svh =====
// assertion macros shared by the cache set rtl
`ifndef CACHE_SET_LRU_REPLACEMENT_TOP_ASSERT_SVH
`define CACHE_SET_LRU_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache set check failed");

// next-cycle implication, checked out of reset
`define CSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache set check failed");

`endif

// ===== hw/rtl/csl_pkg.sv =====
// shared types and constants for the cache set lru block
package csl_pkg;

  localparam int TAG_W  = 32;
  localparam int CMD_W  = 2;
  localparam int WAYS_W = 5;
  localparam int BYTES_W = 13;
  localparam int COST_W = 17;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL  = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_TOUCH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_WAYS  = 1'd0,
    CFG_BLOCK = 1'd1
  } cfg_index_t;

  localparam logic [WAYS_W-1:0]  WAYS_RESET      = 5'd4;
  localparam logic [BYTES_W-1:0] BLOCK_RESET     = 13'd16;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_MAX = 13'd4096;
  localparam logic [COST_W-1:0]  WB_FACTOR       = 17'd100;
  localparam int                 WORD_SHIFT      = 2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             fill;
    logic             evict;
    logic             mark;
    logic             touch;
    logic [TAG_W-1:0] tag;
    logic             new_dirty;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/csl_in_if.sv =====
// command channel of the cache set
interface csl_in_if;
  logic                     valid;
  logic                     ready;
  logic [csl_pkg::CMD_W-1:0] cmd;
  logic [csl_pkg::TAG_W-1:0] tag;
  logic                     new_dirty;

  modport source (output valid, cmd, tag, new_dirty, input ready);
  modport sink   (input valid, cmd, tag, new_dirty, output ready);
endinterface

// ===== hw/rtl/csl_out_if.sv =====
// result channel of the cache set
interface csl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       evicted;
  logic [csl_pkg::TAG_W-1:0]  evicted_tag;
  logic [csl_pkg::COST_W-1:0] writeback_cycles;

  modport source (output valid, found, evicted, evicted_tag, writeback_cycles, input ready);
  modport sink   (input valid, found, evicted, evicted_tag, writeback_cycles, output ready);
endinterface

// ===== hw/rtl/csl_cell.sv =====
// one way of the set: tag, dirty mark, first-match ripple and shift from the newer neighbour
module csl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  csl_pkg::cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]          count,
  input  logic                      hit_in,
  input  logic                      hit_dirty_in,
  input  logic [csl_pkg::TAG_W-1:0] upper_tag,
  input  logic                      upper_dirty,
  output logic                      hit_out,
  output logic                      hit_dirty_out,
  output logic [csl_pkg::TAG_W-1:0] tag_q,
  output logic                      dirty_q
);

  localparam logic [CNT_W:0] IDX_W  = (CNT_W+1)'(IDX);
  localparam logic [CNT_W:0] IDX_P1 = (CNT_W+1)'(IDX + 1);

  logic [CNT_W:0]          cnt;
  logic                    occupied;
  logic                    match;
  logic                    first;
  logic [csl_pkg::TAG_W-1:0] tag_next;
  logic                    dirty_next;

  assign cnt      = {1'b0, count};
  assign occupied = IDX_W < cnt;
  assign match    = occupied && (tag_q == ctrl.tag);
  assign first    = match && !hit_in;
  assign hit_out  = hit_in || match;
  // carries the dirty mark of the oldest match towards the newest end
  assign hit_dirty_out = hit_in ? hit_dirty_in : dirty_q;

  always_comb begin
    tag_next   = tag_q;
    dirty_next = dirty_q;
    priority if (ctrl.fill && ctrl.evict && IDX_P1 < cnt) begin
      tag_next   = upper_tag;
      dirty_next = upper_dirty;
    end else if (ctrl.fill && ctrl.evict && IDX_P1 == cnt) begin
      tag_next   = ctrl.tag;
      dirty_next = ctrl.new_dirty;
    end else if (ctrl.fill && !ctrl.evict && IDX_W == cnt) begin
      tag_next   = ctrl.tag;
      dirty_next = ctrl.new_dirty;
    end else if (ctrl.mark && first) begin
      dirty_next = 1'b1;
    end else if (ctrl.touch && hit_out && IDX_P1 < cnt) begin
      tag_next   = upper_tag;
      dirty_next = upper_dirty;
    end else if (ctrl.touch && hit_out && IDX_P1 == cnt) begin
      // matched entry reappears as the newest
      tag_next   = ctrl.tag;
      dirty_next = hit_dirty_out;
    end else begin
      tag_next   = tag_q;
      dirty_next = dirty_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_q <= 1'b0;
    end else begin
      dirty_q <= dirty_next;
    end
    tag_q <= tag_next;
  end

endmodule

// ===== hw/rtl/cache_set_lru_replacement_top.sv =====
// top level of one write-back cache set with lru replacement
//
//   channel | dir | handshake          | payload
//   req     | in  | valid / ready      | cmd, tag, new_dirty
//   rsp     | out | valid / ready      | found, evicted, evicted_tag, writeback_cycles
//   cfg     | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// for each item the tag compare ripples along the row of cells and
// the set updates on the accepting edge; the result appears in the output register
// on the next cycle. req is ready whenever the output register is empty or drains.
// synchronous reset empties the set and restores ways 4 and block bytes 16.
// a stalled result holds the register and blocks only further items.
module cache_set_lru_replacement_top #(
  parameter int MAX_WAYS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  csl_in_if.sink                          req,
  csl_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [csl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "cache_set_lru_replacement_top_assert.svh"

  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int EW    = (CNT_W > csl_pkg::WAYS_W) ? CNT_W : csl_pkg::WAYS_W;
  localparam logic [EW-1:0]    MAXW_E = EW'(MAX_WAYS);
  localparam logic [CNT_W-1:0] MAXW_C = CNT_W'(MAX_WAYS);

  logic [csl_pkg::WAYS_W-1:0]  ways_in_use;
  logic [csl_pkg::BYTES_W-1:0] block_bytes;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;

  logic                        rsp_valid;
  logic                        res_found;
  logic                        res_evicted;
  logic [csl_pkg::TAG_W-1:0]   res_evicted_tag;
  logic [csl_pkg::COST_W-1:0]  res_writeback_cycles;

  logic                        acc;
  csl_pkg::cmd_t               cmd;
  csl_pkg::cell_ctrl_t         ctrl;
  logic [EW-1:0]               ways_lo;
  logic [EW-1:0]               eff_ways;
  logic [EW-1:0]               count_e;
  logic [csl_pkg::BYTES_W-1:0] bytes_clamped;
  logic [csl_pkg::COST_W-1:0]  cost;

  logic                        hit_chain   [MAX_WAYS+1];
  logic                        hdirty_chain[MAX_WAYS+1];
  logic [csl_pkg::TAG_W-1:0]   tag_row     [MAX_WAYS+1];
  logic                        dirty_row   [MAX_WAYS+1];

  assign acc       = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign cmd       = csl_pkg::cmd_t'(req.cmd);

  // ways 0 acts as 1, anything past the row acts as the full row
  assign ways_lo  = (ways_in_use == '0) ? EW'(1) : EW'(ways_in_use);
  assign eff_ways = (ways_lo > MAXW_E) ? MAXW_E : ways_lo;
  assign count_e  = EW'(count);

  assign ctrl.fill      = acc && (cmd == csl_pkg::CMD_FILL);
  assign ctrl.mark      = acc && (cmd == csl_pkg::CMD_MARK);
  assign ctrl.touch     = acc && (cmd == csl_pkg::CMD_TOUCH);
  assign ctrl.evict     = ctrl.fill && (count != '0) && (count_e >= eff_ways);
  assign ctrl.tag       = req.tag;
  assign ctrl.new_dirty = req.new_dirty;

  assign bytes_clamped = (block_bytes > csl_pkg::BLOCK_BYTES_MAX) ?
                         csl_pkg::BLOCK_BYTES_MAX : block_bytes;
  assign cost = csl_pkg::WB_FACTOR *
                csl_pkg::COST_W'(bytes_clamped >> csl_pkg::WORD_SHIFT);

  assign hit_chain[0]         = 1'b0;
  assign hdirty_chain[0]      = 1'b0;
  assign tag_row[MAX_WAYS]    = '0;
  assign dirty_row[MAX_WAYS]  = 1'b0;

  for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
    csl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .count         (count),
      .hit_in        (hit_chain[i]),
      .hit_dirty_in  (hdirty_chain[i]),
      .upper_tag     (tag_row[i+1]),
      .upper_dirty   (dirty_row[i+1]),
      .hit_out       (hit_chain[i+1]),
      .hit_dirty_out (hdirty_chain[i+1]),
      .tag_q         (tag_row[i]),
      .dirty_q       (dirty_row[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.fill && !ctrl.evict && count < MAXW_C) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= csl_pkg::WAYS_RESET;
      block_bytes <= csl_pkg::BLOCK_RESET;
      count       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (csl_pkg::cfg_index_t'(cfg_index))
          csl_pkg::CFG_WAYS:  ways_in_use <= cfg_data[csl_pkg::WAYS_W-1:0];
          csl_pkg::CFG_BLOCK: block_bytes <= cfg_data[csl_pkg::BYTES_W-1:0];
          default: ;
        endcase
      end
      count <= count_next;
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_found            <= ctrl.fill || ((ctrl.mark || ctrl.touch) && hit_chain[MAX_WAYS]);
      res_evicted          <= ctrl.evict;
      res_evicted_tag      <= ctrl.evict ? tag_row[0] : '0;
      res_writeback_cycles <= (ctrl.evict && dirty_row[0]) ? cost : '0;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.found            = res_found;
  assign rsp.evicted          = res_evicted;
  assign rsp.evicted_tag      = res_evicted_tag;
  assign rsp.writeback_cycles = res_writeback_cycles;

  `CSL_ASSERT_NOW(a_count_bound, 1'b1, count <= MAXW_C)
  `CSL_ASSERT_NEXT(a_fill_grows, ctrl.fill && !ctrl.evict, count == $past(count) + CNT_W'(1))
  `CSL_ASSERT_NEXT(a_evict_reported, ctrl.evict, rsp.valid && rsp.evicted && rsp.found)
  `CSL_ASSERT_NEXT(a_touch_keeps_count, ctrl.touch || ctrl.mark, $stable(count))

endmodule

// ===== dv/testbench.sv =====
// testbench for the lru cache set: directed table, random access phases, scoreboard
`timescale 1ns / 100ps

module testbench;
  import csl_pkg::*;

  localparam int SET_WAYS    = 16;
  localparam int PLAN_LEN    = 29;
  localparam int PHASES      = 31;
  localparam int PHASE_ITEMS = 50;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic               found;
    logic               evicted;
    logic [TAG_W-1:0]   evicted_tag;
    logic [COST_W-1:0]  writeback_cycles;
  } set_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    cfg_index_t             reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    cmd_t                   cmd;
    logic [TAG_W-1:0]       tag;
    logic                   new_dirty;
    logic                   typed;
    set_result_t            want;
  } plan_row_t;

  localparam set_result_t NO_HIT   = '0;
  localparam set_result_t HIT_ONLY = '{1'b1, 1'b0, 32'h0, 17'h0};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csl_in_if  req_if ();
  csl_out_if rsp_if ();

  cache_set_lru_replacement_top #(.MAX_WAYS(SET_WAYS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the set, oldest entry at index 0
  logic [TAG_W-1:0]   set_tags [SET_WAYS];
  logic               set_dirty [SET_WAYS];
  int                 fill_level;
  logic [WAYS_W-1:0]  ways_cfg;
  logic [BYTES_W-1:0] bytes_cfg;

  set_result_t pending_results [$];
  plan_row_t   directed_plan [0:PLAN_LEN-1];
  logic [TAG_W-1:0] tag_pool [8];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < fill_level; i++) begin
      set_tags[i]  = set_tags[i + 1];
      set_dirty[i] = set_dirty[i + 1];
    end
    fill_level--;
  endfunction

  function automatic set_result_t lru_access(cmd_t c, logic [TAG_W-1:0] t, logic nd);
    set_result_t r;
    int eff_ways;
    int pos;
    int bb;
    logic [TAG_W-1:0] moved_tag;
    logic moved_dirty;
    r = '0;
    eff_ways = (ways_cfg == 0) ? 1 : ((ways_cfg > SET_WAYS) ? SET_WAYS : int'(ways_cfg));
    case (c)
      CMD_FILL: begin
        r.found = 1'b1;
        if (fill_level >= eff_ways && fill_level > 0) begin
          bb = (bytes_cfg > BLOCK_BYTES_MAX) ? int'(BLOCK_BYTES_MAX) : int'(bytes_cfg);
          r.evicted = 1'b1;
          r.evicted_tag = set_tags[0];
          if (set_dirty[0]) r.writeback_cycles = COST_W'(int'(WB_FACTOR) * (bb >> WORD_SHIFT));
          drop_entry(0);
        end
        if (fill_level < SET_WAYS) begin
          set_tags[fill_level]  = t;
          set_dirty[fill_level] = nd;
          fill_level++;
        end
      end
      CMD_MARK, CMD_TOUCH: begin
        pos = fill_level;
        for (int i = fill_level - 1; i >= 0; i--)
          if (set_tags[i] == t) pos = i;
        if (pos < fill_level) begin
          r.found = 1'b1;
          if (c == CMD_MARK) begin
            set_dirty[pos] = 1'b1;
          end else begin
            moved_tag   = set_tags[pos];
            moved_dirty = set_dirty[pos];
            drop_entry(pos);
            set_tags[fill_level]  = moved_tag;
            set_dirty[fill_level] = moved_dirty;
            fill_level++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_access(cmd_t c, logic [TAG_W-1:0] t, logic nd, bit typed,
                             set_result_t want);
    int gap;
    set_result_t model;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= c;
    req_if.tag       <= t;
    req_if.new_dirty <= nd;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    model = lru_access(c, t, nd);
    pending_results.insert(pending_results.size(), typed ? want : model);
  endtask

  // hold off new items until every result is back, then let the set settle
  task automatic drain_set;
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WAYS) ways_cfg = val[WAYS_W-1:0];
    else bytes_cfg = val[BYTES_W-1:0];
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    set_result_t want;
    rsp_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, got found %0b tag %0h", $time,
                 rsp_if.found, rsp_if.evicted_tag);
      end else begin
        want = pending_results.pop_front();
        check_field("found", TAG_W'(want.found), TAG_W'(rsp_if.found));
        check_field("evicted", TAG_W'(want.evicted), TAG_W'(rsp_if.evicted));
        check_field("evicted_tag", want.evicted_tag, rsp_if.evicted_tag);
        check_field("writeback_cycles", TAG_W'(want.writeback_cycles),
                    TAG_W'(rsp_if.writeback_cycles));
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    logic [TAG_W-1:0] t;
    logic [WAYS_W-1:0] w;
    logic [CFG_DATA_W-1:0] b;
    int roll;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_WAYS;
    cfg_data         <= '0;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_FILL;
    req_if.tag       <= '0;
    req_if.new_dirty <= 1'b0;

    fill_level = 0;
    ways_cfg   = WAYS_RESET;
    bytes_cfg  = BLOCK_RESET;
    foreach (set_tags[i]) begin
      set_tags[i]  = '0;
      set_dirty[i] = 1'b0;
    end

    directed_plan = '{
      // empty set: misses and the unused command
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_TOUCH, 32'h0000_0000, 1'b0, 1'b1, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_MARK, 32'hFFFF_FFFF, 1'b0, 1'b1, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1, NO_HIT},
      // fill to four ways, with a duplicate tag
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h0000_0000, 1'b1, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'hFFFF_FFFF, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h1234_5678, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h1234_5678, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_MARK, 32'h1234_5678, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'hA5A5_A5A5, 1'b0, 1'b1,
        '{1'b1, 1'b1, 32'h0000_0000, 17'd400}},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_TOUCH, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h5A5A_5A5A, 1'b1, 1'b0, NO_HIT},
      // block size above the maximum is clamped
      '{ROW_CFG, CFG_BLOCK, 13'd8191, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_MARK, 32'h1234_5678, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h0000_0001, 1'b1, 1'b1,
        '{1'b1, 1'b1, 32'h1234_5678, 17'd102400}},
      // block size below one word costs nothing
      '{ROW_CFG, CFG_BLOCK, 13'd3, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_MARK, 32'hA5A5_A5A5, 1'b0, 1'b1, HIT_ONLY},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h0000_0002, 1'b0, 1'b1,
        '{1'b1, 1'b1, 32'hA5A5_A5A5, 17'd0}},
      // zero ways acts as one, set stays overfull
      '{ROW_CFG, CFG_WAYS, 13'd0, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_CFG, CFG_BLOCK, 13'd4096, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h0000_0003, 1'b1, 1'b1,
        '{1'b1, 1'b1, 32'hFFFF_FFFF, 17'd0}},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_TOUCH, 32'h5A5A_5A5A, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h0000_0004, 1'b0, 1'b0, NO_HIT},
      // way count above the maximum acts as the maximum
      '{ROW_CFG, CFG_WAYS, 13'd31, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_CFG, CFG_BLOCK, 13'd4, CMD_FILL, 32'h0, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_TOUCH, 32'hDEAD_BEEF, 1'b0, 1'b1, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_MARK, 32'h0000_0003, 1'b0, 1'b0, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_NONE, 32'h0000_0000, 1'b0, 1'b1, NO_HIT},
      '{ROW_ITEM, CFG_WAYS, 13'd0, CMD_FILL, 32'h8000_0000, 1'b0, 1'b0, NO_HIT}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        drain_set();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_access(directed_plan[i].cmd, directed_plan[i].tag, directed_plan[i].new_dirty,
                    directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_set();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      foreach (tag_pool[i]) tag_pool[i] = $urandom;

      if ($urandom_range(0, 2) != 0) begin
        roll = $urandom_range(0, 9);
        case (roll)
          0: w = 5'd0;
          1: w = 5'd31;
          2: w = 5'd17;
          3: w = 5'd16;
          4: w = 5'd1;
          5, 6: w = WAYS_W'($urandom_range(1, 16));
          default: w = WAYS_W'($urandom_range(1, 5));
        endcase
        // upper data bits are ignored by the way count
        b = {8'($urandom_range(0, 255)), w};
        if ($urandom_range(0, 1) == 0) b[CFG_DATA_W-1:WAYS_W] = '0;
        write_reg(CFG_WAYS, b);
      end
      if ($urandom_range(0, 2) != 0) begin
        roll = $urandom_range(0, 11);
        case (roll)
          0: b = 13'd0;
          1: b = 13'd3;
          2: b = 13'd4;
          3: b = 13'd4096;
          4: b = 13'd4097;
          5: b = 13'd8191;
          default: b = CFG_DATA_W'($urandom_range(4, 4096));
        endcase
        write_reg(CFG_BLOCK, b);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) drain_set();
        roll = $urandom_range(0, 99);
        if (roll < 45) c = CMD_FILL;
        else if (roll < 65) c = CMD_MARK;
        else if (roll < 90) c = CMD_TOUCH;
        else c = CMD_NONE;
        roll = $urandom_range(0, 99);
        if (c != CMD_FILL && fill_level > 0 && roll < 60)
          t = set_tags[$urandom_range(0, fill_level - 1)];
        else if (roll < 85)
          t = tag_pool[$urandom_range(0, 7)];
        else
          t = $urandom;
        send_access(c, t, 1'($urandom_range(0, 1)), 1'b0, NO_HIT);
      end
    end

    drain_set();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
